// ===== hw/rtl/rea_pkg.sv =====
// shared types and constants of the rotary encoder counter
`default_nettype none

package rea_pkg;

   // request codes of the input item, code 3 only reports the count
   localparam logic [1:0] REQ_SAMPLE = 2'd0;
   localparam logic [1:0] REQ_ATTACH = 2'd1;
   localparam logic [1:0] REQ_CLEAR  = 2'd2;

   // register indexes of the write port
   localparam logic CSR_FAST_GAP  = 1'b0;
   localparam logic CSR_FAST_STEP = 1'b1;

   localparam logic [7:0] FAST_GAP_RESET  = 8'd3;
   localparam logic [7:0] FAST_STEP_RESET = 8'd5;

   localparam int INDEX_W    = 3;
   localparam int STAMP_W    = 32;
   localparam int TALLY_W    = 16;
   localparam int MAX_DEPTH  = 8;

   typedef struct packed {
      logic                 level_a;
      logic                 level_b;
      logic [STAMP_W-1:0]   stamp;
      logic [TALLY_W-1:0]   tally;
   } entry_type;

   typedef struct packed {
      logic [7:0] fast_gap;
      logic [7:0] fast_step;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rea_update.sv =====
// next value of one encoder entry for one request
`default_nettype none

module rea_update (
   input  var rea_pkg::entry_type  cur_entry,
   input  var rea_pkg::cfg_type    cfg,
   input  var logic [1:0]          req_kind,
   input  var logic                pin_a,
   input  var logic                pin_b,
   input  var logic [31:0]         now_ms,
   output rea_pkg::entry_type      next_entry
);
   import rea_pkg::*;

   logic                edge_up;
   logic                edge_down;
   logic [STAMP_W-1:0]  gap;
   logic                fast;
   logic [TALLY_W-1:0]  step;
   entry_type           sampled;

   // a rising a needs b low, a rising b needs the new a low: never both
   assign edge_up   = (pin_a != cur_entry.level_a) && pin_a && !cur_entry.level_b;
   assign edge_down = (pin_b != cur_entry.level_b) && pin_b && !pin_a;
   assign gap       = now_ms - cur_entry.stamp;
   assign fast      = gap <= {{(STAMP_W-8){1'b0}}, cfg.fast_gap};
   assign step      = fast ? {{(TALLY_W-8){1'b0}}, cfg.fast_step} : TALLY_W'(1);

   always_comb begin
      sampled         = cur_entry;
      sampled.level_a = pin_a;
      sampled.level_b = pin_b;
      if (edge_up) begin
         sampled.tally = cur_entry.tally + step;
         sampled.stamp = now_ms;
      end else if (edge_down) begin
         sampled.tally = cur_entry.tally - step;
         sampled.stamp = now_ms;
      end
   end

   always_comb begin
      next_entry = cur_entry;
      unique case (req_kind)
         REQ_SAMPLE: next_entry = sampled;
         REQ_ATTACH: begin
            next_entry.level_a = pin_a;
            next_entry.level_b = pin_b;
            next_entry.stamp   = '0;
         end
         REQ_CLEAR:  next_entry.tally = '0;
         default:    next_entry = cur_entry;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rea_table.sv =====
// flip-flop table of encoder entries, one read and one write port
`default_nettype none

module rea_table #(
   parameter int DEPTH = 8,
   parameter int IDX_W = 3
) (
   input  var logic                clock,
   input  var logic                reset,
   input  var logic [IDX_W-1:0]    rd_index,
   output rea_pkg::entry_type      rd_entry,
   input  var logic                wr_en,
   input  var logic [IDX_W-1:0]    wr_index,
   input  var rea_pkg::entry_type  wr_entry
);
   import rea_pkg::*;

   entry_type entries_ff [DEPTH];
   entry_type entries_in [DEPTH];

   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         entries_in[i] = entries_ff[i];
         if (wr_en && (wr_index == IDX_W'(i))) begin
            entries_in[i] = wr_entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         if (reset) begin
            entries_ff[i] <= '0;
         end else begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

   assign rd_entry = entries_ff[rd_index];

endmodule

`default_nettype wire

// ===== hw/rtl/rotary_encoder_accel_counter.sv =====
// top level: rotary encoder table with edge counting and fast-step acceleration
//
//   port group   dir   transfer rule                  payload
//   req_*        in    req_valid  && !req_stall       type, index, pins, ms tick
//   rsp_*        out   rsp_valid  && !rsp_stall       encoder id, signed position
//   csr_*        in    csr_write_en                   index 0 fast gap, 1 fast step
//
// one item per cycle sustained while rsp_stall is low; a request passes through the
// input register, where the entry is read, updated and written back while the
// result register loads, so rsp_valid rises in the cycle after the item leaves
// the input register and the result transfers in a cycle where rsp_stall is low
// the write-back lands at the same edge the result loads, so the next item
// always reads the updated entry
// reset (synchronous) zeroes the table and restores gap 3, step 5
// a stalled result register holds the input register, which then stalls req
`default_nettype none

module rotary_encoder_accel_counter #(
   parameter int NUM_ENCODERS = 8
) (
   input  var logic                  clock,
   input  var logic                  reset,
   // request channel
   input  var logic                  req_valid,
   output logic                      req_stall,
   input  var logic [1:0]            req_type,
   input  var logic [2:0]            req_encoder_index,
   input  var logic                  req_pin_a,
   input  var logic                  req_pin_b,
   input  var logic [31:0]           req_now_ms,
   // result channel
   output logic                      rsp_valid,
   input  var logic                  rsp_stall,
   output logic [2:0]                rsp_encoder_id,
   output logic signed [15:0]        rsp_position,
   // register write port
   input  var logic                  csr_write_en,
   input  var logic                  csr_index,
   input  var logic [7:0]            csr_write_data
);
   import rea_pkg::*;

   // only indexes 0..7 can be addressed, so larger tables keep eight entries
   localparam int DEPTH = (NUM_ENCODERS < MAX_DEPTH) ? NUM_ENCODERS : MAX_DEPTH;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W = 8;

   // configuration
   cfg_type             cfg_ff;
   cfg_type             cfg_in;

   // input register
   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [1:0]          kind_ff;
   logic [INDEX_W-1:0]  index_ff;
   logic                pin_a_ff;
   logic                pin_b_ff;
   logic [STAMP_W-1:0]  now_ff;

   // result register
   logic                out_valid_ff;
   logic                out_valid_in;
   logic [INDEX_W-1:0]  out_id_ff;
   logic [TALLY_W-1:0]  out_pos_ff;

   logic                advance;
   logic                req_take;
   logic                in_range;
   entry_type           cur_entry;
   entry_type           next_entry;

   // the input register moves on when the result register is empty or draining
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign in_range  = {{(CMP_W-INDEX_W){1'b0}}, index_ff} < CMP_W'(NUM_ENCODERS);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_FAST_GAP:  cfg_in.fast_gap  = csr_write_data;
            CSR_FAST_STEP: cfg_in.fast_step = csr_write_data;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fast_gap  <= FAST_GAP_RESET;
         cfg_ff.fast_step <= FAST_STEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // input register: valid follows the transfer, payload loads on transfer
   assign s1_valid_in = req_take || (s1_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff  <= req_type;
         index_ff <= req_encoder_index;
         pin_a_ff <= req_pin_a;
         pin_b_ff <= req_pin_b;
         now_ff   <= req_now_ms;
      end
   end

   rea_table #(
      .DEPTH (DEPTH),
      .IDX_W (IDX_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_index (index_ff[IDX_W-1:0]),
      .rd_entry (cur_entry),
      .wr_en    (s1_valid_ff && advance && in_range),
      .wr_index (index_ff[IDX_W-1:0]),
      .wr_entry (next_entry)
   );

   rea_update u_update (
      .cur_entry  (cur_entry),
      .cfg        (cfg_ff),
      .req_kind   (kind_ff),
      .pin_a      (pin_a_ff),
      .pin_b      (pin_b_ff),
      .now_ms     (now_ff),
      .next_entry (next_entry)
   );

   // result register
   assign out_valid_in = (s1_valid_ff && advance) || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && advance) begin
         out_id_ff  <= index_ff;
         // an index past the table reports zero and changes nothing
         out_pos_ff <= in_range ? next_entry.tally : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_encoder_id = out_id_ff;
   assign rsp_position   = $signed(out_pos_ff);

   // a stall toward the request side only comes with an occupied input register
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("req_stall without an item in the input register");

   // an item that leaves the input register shows up as a result
   a_item_to_result: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance) |=> out_valid_ff)
      else $error("item left the input register without a result");

   // a count clear in range reports zero
   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && (kind_ff == REQ_CLEAR)) |=> (out_pos_ff == '0))
      else $error("count clear did not report zero");

   // an index past the table reports zero
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && advance && !in_range) |=> (out_pos_ff == '0))
      else $error("index past the table reported a nonzero position");

endmodule

`default_nettype wire
